>>> rtl/core/median_filter_3x3_core_defines.svh
`ifndef MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CORE_DEFINES_SVH

// Same-cycle implication on the block clock, off during reset.
`define MF3_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the block clock, off during reset.
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mf3_pkg.sv
package mf3_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 11;
    localparam int FW_W      = 12;
    localparam int FH_W      = 16;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [OUT_COL_W-1:0] ocol_t;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        pix_t hi;
        pix_t md;
        pix_t lo;
    } col3_t;

    typedef struct packed {
        logic rge1;
        logic cge1;
        logic interior;
        logic row_end;
        logic last_row;
    } flags_t;

    typedef struct packed {
        pix_t  pixel;
        row_t  row;
        ocol_t col;
    } result_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return min2(max2(a, b), max2(min2(a, b), c));
    endfunction

    function automatic col3_t sort3(input pix_t a, input pix_t b, input pix_t c);
        col3_t r;
        pix_t  lo1;
        pix_t  hi1;
        pix_t  t;
        lo1  = min2(a, b);
        hi1  = max2(a, b);
        t    = max2(lo1, c);
        r.lo = min2(lo1, c);
        r.md = min2(hi1, t);
        r.hi = max2(hi1, t);
        return r;
    endfunction

endpackage

>>> rtl/core/median_filter_3x3_core.sv
// 3x3 median filter over an 8-bit grayscale frame in raster order.
// Input channel (s_valid/s_ready/s_pixel_in): one pixel per request.
// Result channel (m_*): filtered pixel with its row and column; border pixels
// pass through unchanged. A pixel at (r,c) releases (r-1,c-1), at a row end
// also (r-1,last column), and in the last row also (r,c) itself.
// m_last_of_run marks the last result of one input pixel, m_frame_done the
// final result of the frame.
// The first result of a pixel passes the line store read, column sort and
// median tree stages, then the output register.
// Throughput: one pixel per cycle while each pixel yields at most one result
// and m_ready is high; a pixel with two or three results holds the output
// register until each result has been taken at the single result port.
// The line store is one single-port-write, registered-read memory of
// MAX_WIDTH words; a write and a read of the same column in one cycle are
// forwarded. Reset (aresetn low, synchronous): counters to row 0 column 0,
// frame size to 640x480, pipeline and output empty; line store content stays
// undefined. When m_ready is low the result is held, the pipeline fills,
// then s_ready drops. The user must write the frame size through the APB port
// only while the block is idle; the block itself does not enforce this.
module median_filter_3x3_core
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic [ROW_W-1:0]   m_out_row,
    output logic [OUT_COL_W-1:0] m_out_col,
    output logic               m_last_of_run,
    output logic               m_frame_done
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (CW > FW_W) ? CW : FW_W;

    typedef logic [AW-1:0] col_t;
    typedef logic [XW-1:0] colx_t;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    reg_idx_t        reg_idx;
    logic            cfg_write;

    row_t  row_reg;
    col_t  col_reg;
    colx_t fw_x;
    colx_t col_x;
    colx_t last_col_x;
    row_t  last_row_idx;
    flags_t in_flags;
    logic  in_accept;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic               fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;

    logic   s1_valid_reg;
    pix_t   s1_pix_reg;
    row_t   s1_row_reg;
    col_t   s1_col_reg;
    flags_t s1_flags_reg;
    pix_t   top1;
    pix_t   mid1;
    col3_t  new_col;
    logic   s1_leave;

    col3_t win_a_reg;
    col3_t win_b_reg;
    pix_t  prev_mid_reg;

    logic   s2_valid_reg;
    col3_t  s2_a_reg;
    col3_t  s2_b_reg;
    col3_t  s2_c_reg;
    pix_t   s2_border_reg;
    pix_t   s2_mid_reg;
    pix_t   s2_pix_reg;
    row_t   s2_row_reg;
    col_t   s2_col_reg;
    flags_t s2_flags_reg;

    logic   s3_valid_reg;
    pix_t   s3_lo_reg;
    pix_t   s3_md_reg;
    pix_t   s3_hi_reg;
    pix_t   s3_border_reg;
    pix_t   s3_mid_reg;
    pix_t   s3_pix_reg;
    row_t   s3_row_reg;
    col_t   s3_col_reg;
    flags_t s3_flags_reg;
    pix_t   s3_value;
    logic [2:0] s3_present;
    result_t    s3_slot [3];

    logic [2:0] emit_mask_reg;
    result_t    emit_slot_reg [3];
    logic       emit_done_reg;
    logic       emit_single;
    logic       emit_free;
    result_t    emit_sel;

    logic s1_in_ready;
    logic s2_in_ready;
    logic s3_in_ready;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // position decode
    always_comb begin
        fw_x  = XW'(frame_width_reg);
        col_x = XW'(col_reg);
        if (fw_x == '0) begin
            last_col_x = '0;
        end else if (fw_x > XW'(MAX_WIDTH)) begin
            last_col_x = XW'(MAX_WIDTH - 1);
        end else begin
            last_col_x = fw_x - XW'(1);
        end
        if (frame_height_reg == '0) begin
            last_row_idx = '0;
        end else begin
            last_row_idx = frame_height_reg - ROW_W'(1);
        end
        in_flags.rge1     = (row_reg != '0);
        in_flags.cge1     = (col_reg != '0);
        in_flags.row_end  = (col_x >= last_col_x);
        in_flags.last_row = (row_reg >= last_row_idx);
        in_flags.interior = (row_reg >= ROW_W'(2)) && (col_reg >= AW'(2)) &&
                            (row_reg <= last_row_idx) && (col_x <= last_col_x);
    end

    // handshake chain
    assign emit_single = ((emit_mask_reg & (emit_mask_reg - 3'd1)) == 3'd0);
    assign emit_free   = (emit_mask_reg == 3'd0) || (m_ready && emit_single);
    assign s3_in_ready = !s3_valid_reg || emit_free;
    assign s2_in_ready = !s2_valid_reg || s3_in_ready;
    assign s1_in_ready = !s1_valid_reg || s2_in_ready;
    assign s_ready     = s1_in_ready;
    assign in_accept   = s_valid && s1_in_ready;
    assign s1_leave    = s1_valid_reg && s2_in_ready;

    // line store
    always_ff @(posedge aclk) begin
        if (s1_leave) begin
            line_mem[s1_col_reg] <= {mid1, s1_pix_reg};
        end
        if (s1_in_ready) begin
            rd_reg <= line_mem[col_reg];
        end
    end

    // stage 1: column sort
    always_comb begin
        if (fwd_reg) begin
            {top1, mid1} = fwd_data_reg;
        end else begin
            {top1, mid1} = rd_reg;
        end
        new_col = sort3(top1, mid1, s1_pix_reg);
    end

    // stage 3: final median and result slots
    always_comb begin
        s3_value = s3_flags_reg.interior ? med3(s3_lo_reg, s3_md_reg, s3_hi_reg)
                                         : s3_border_reg;
        s3_present[0] = s3_flags_reg.rge1 && s3_flags_reg.cge1;
        s3_present[1] = s3_flags_reg.rge1 && s3_flags_reg.row_end;
        s3_present[2] = s3_flags_reg.last_row;
        s3_slot[0].pixel = s3_value;
        s3_slot[0].row   = s3_row_reg - ROW_W'(1);
        s3_slot[0].col   = OUT_COL_W'(s3_col_reg - AW'(1));
        s3_slot[1].pixel = s3_mid_reg;
        s3_slot[1].row   = s3_row_reg - ROW_W'(1);
        s3_slot[1].col   = OUT_COL_W'(s3_col_reg);
        s3_slot[2].pixel = s3_pix_reg;
        s3_slot[2].row   = s3_row_reg;
        s3_slot[2].col   = OUT_COL_W'(s3_col_reg);
    end

    // output: lowest pending slot first
    always_comb begin
        if (emit_mask_reg[0]) begin
            emit_sel = emit_slot_reg[0];
        end else if (emit_mask_reg[1]) begin
            emit_sel = emit_slot_reg[1];
        end else begin
            emit_sel = emit_slot_reg[2];
        end
    end

    assign m_valid       = (emit_mask_reg != 3'd0);
    assign m_pixel_out   = emit_sel.pixel;
    assign m_out_row     = emit_sel.row;
    assign m_out_col     = emit_sel.col;
    assign m_last_of_run = emit_single;
    assign m_frame_done  = emit_single && emit_done_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_W'(640);
            frame_height_reg <= FH_W'(480);
            row_reg          <= '0;
            col_reg          <= '0;
            fwd_reg          <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            emit_mask_reg    <= 3'd0;
        end else begin
            if (cfg_write) begin
                case (reg_idx)
                    REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                if (in_flags.row_end) begin
                    col_reg <= '0;
                    row_reg <= in_flags.last_row ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + AW'(1);
                end
            end
            if (s1_in_ready) begin
                s1_valid_reg <= s_valid;
                fwd_reg      <= s_valid && s1_leave && (col_reg == s1_col_reg);
            end
            if (s2_in_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_in_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (emit_free) begin
                emit_mask_reg <= s3_valid_reg ? s3_present : 3'd0;
            end else if (m_ready) begin
                emit_mask_reg <= emit_mask_reg & (emit_mask_reg - 3'd1);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s1_in_ready) begin
            s1_pix_reg   <= s_pixel_in;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= in_flags;
            fwd_data_reg <= {mid1, s1_pix_reg};
        end
        if (s1_leave) begin
            win_a_reg    <= win_b_reg;
            win_b_reg    <= new_col;
            prev_mid_reg <= mid1;
        end
        if (s2_in_ready) begin
            s2_a_reg      <= win_a_reg;
            s2_b_reg      <= win_b_reg;
            s2_c_reg      <= new_col;
            s2_border_reg <= prev_mid_reg;
            s2_mid_reg    <= mid1;
            s2_pix_reg    <= s1_pix_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_flags_reg  <= s1_flags_reg;
        end
        if (s3_in_ready) begin
            s3_lo_reg     <= max3(s2_a_reg.lo, s2_b_reg.lo, s2_c_reg.lo);
            s3_md_reg     <= med3(s2_a_reg.md, s2_b_reg.md, s2_c_reg.md);
            s3_hi_reg     <= min3(s2_a_reg.hi, s2_b_reg.hi, s2_c_reg.hi);
            s3_border_reg <= s2_border_reg;
            s3_mid_reg    <= s2_mid_reg;
            s3_pix_reg    <= s2_pix_reg;
            s3_row_reg    <= s2_row_reg;
            s3_col_reg    <= s2_col_reg;
            s3_flags_reg  <= s2_flags_reg;
        end
        if (emit_free) begin
            emit_slot_reg[0] <= s3_slot[0];
            emit_slot_reg[1] <= s3_slot[1];
            emit_slot_reg[2] <= s3_slot[2];
            emit_done_reg    <= s3_flags_reg.row_end && s3_flags_reg.last_row;
        end
    end

`include "median_filter_3x3_core_defines.svh"

    `MF3_ASSERT_SAME(a_fwd_has_item, fwd_reg, s1_valid_reg, "forward flag without item")
    `MF3_ASSERT_NEXT(a_accept_fills_s1, s_valid && s_ready, s1_valid_reg, "accepted pixel lost")
    `MF3_ASSERT_NEXT(a_emit_one_step, m_valid && m_ready && !m_last_of_run,
        $countones(emit_mask_reg) == $countones($past(emit_mask_reg)) - 1,
        "result slot skipped or repeated")
    `MF3_ASSERT_SAME(a_done_has_copy, emit_done_reg && (emit_mask_reg != 3'd0),
        emit_mask_reg[2], "frame end without last-row copy")

endmodule
